>>> hw/rtl/umec_pkg.sv
// Package for the universal machine execute core: event codes, opcodes, widths.
// No dependencies.
`timescale 1ns / 1ps
package umec_pkg;
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = $clog2(REG_COUNT);

    localparam logic [3:0] EV_DONE      = 4'd0;
    localparam logic [3:0] EV_READ      = 4'd1;
    localparam logic [3:0] EV_WRITE     = 4'd2;
    localparam logic [3:0] EV_MAP       = 4'd3;
    localparam logic [3:0] EV_UNMAP     = 4'd4;
    localparam logic [3:0] EV_OUTPUT    = 4'd5;
    localparam logic [3:0] EV_INPUT     = 4'd6;
    localparam logic [3:0] EV_LOADPROG  = 4'd7;
    localparam logic [3:0] EV_HALT      = 4'd8;
    localparam logic [3:0] EV_BADOP     = 4'd9;
    localparam logic [3:0] EV_DIVZERO   = 4'd10;
    localparam logic [3:0] EV_BADOUT    = 4'd11;
    localparam logic [3:0] EV_UNMAPZERO = 4'd12;
    localparam logic [3:0] EV_NOTREADY  = 4'd13;

    localparam logic [3:0] OP_CMOV  = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_STORE = 4'd2;
    localparam logic [3:0] OP_ADD   = 4'd3;
    localparam logic [3:0] OP_MUL   = 4'd4;
    localparam logic [3:0] OP_DIV   = 4'd5;
    localparam logic [3:0] OP_NAND  = 4'd6;
    localparam logic [3:0] OP_HALT  = 4'd7;
    localparam logic [3:0] OP_MAP   = 4'd8;
    localparam logic [3:0] OP_UNMAP = 4'd9;
    localparam logic [3:0] OP_OUT   = 4'd10;
    localparam logic [3:0] OP_IN    = 4'd11;
    localparam logic [3:0] OP_LDPRG = 4'd12;
    localparam logic [3:0] OP_LDIMM = 4'd13;

    localparam logic ACTION_EXEC  = 1'b0;
    localparam logic ACTION_REPLY = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] instruction;
        logic [31:0] reply_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [31:0] segment_id;
        logic [31:0] word_offset;
        logic [31:0] data_value;
        logic [31:0] next_pc;
    } t_out_item;

    // Control between the sequencer and the shared arithmetic unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } t_alu_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_stat;
endpackage

>>> hw/rtl/umec_if.sv
// Valid/ready channel interfaces for the universal machine execute core.
// Depends on umec_pkg for the item types.
`timescale 1ns / 1ps
interface umec_in_if;
    logic              valid;
    logic              ready;
    umec_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface umec_out_if;
    logic               valid;
    logic               ready;
    umec_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/umec_alu.sv
// Shared multi-cycle multiply/divide unit: one bit of the operand per cycle.
// Depends on umec_pkg for the control and status structs.
`timescale 1ns / 1ps
module umec_alu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  umec_pkg::t_alu_ctrl i_ctrl,
    input  logic [31:0]         i_op_b,
    input  logic [31:0]         i_op_c,
    output umec_pkg::t_alu_stat o_stat,
    output logic [31:0]         o_result
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_is_div, n_is_div;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_acc, n_acc;     // product or remainder
    logic [31:0] r_q, n_q;         // multiplier bits or dividend/quotient
    logic [31:0] r_d, n_d;         // multiplicand or divisor
    logic [32:0] w_trial;

    assign w_trial = {r_acc, r_q[31]} - {1'b0, r_d};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_is_div = r_is_div;
        n_cnt = r_cnt;
        n_acc = r_acc;
        n_q = r_q;
        n_d = r_d;
        if (i_ctrl.start) begin
            n_busy = 1'b1;
            n_is_div = i_ctrl.is_div;
            n_cnt = 6'd32;
            n_acc = '0;
            n_q = i_op_b;
            n_d = i_op_c;
        end else if (r_busy) begin
            if (r_is_div) begin
                if (!w_trial[32]) begin
                    n_acc = w_trial[31:0];
                    n_q = {r_q[30:0], 1'b1};
                end else begin
                    n_acc = {r_acc[30:0], r_q[31]};
                    n_q = {r_q[30:0], 1'b0};
                end
            end else begin
                // Shift-add multiply from the top bit of B down.
                n_acc = {r_acc[30:0], 1'b0} + (r_q[31] ? r_d : 32'd0);
                n_q = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_is_div <= n_is_div;
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_q <= n_q;
        r_d <= n_d;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result = r_is_div ? r_q : r_acc;
endmodule

>>> hw/rtl/universal_machine_execute_core.sv
// Top level of the universal machine execute core: decode, register file, sequencer.
// Depends on umec_pkg, umec_if and umec_alu.
`timescale 1ns / 1ps
// Usage:
// Items enter on in_ch: an action bit, an instruction word and a reply value.
// Action 0 executes the instruction; action 1 delivers the reply to the
// outstanding load, map or input request, whose value lands in the target
// register. Every accepted item yields exactly one item on out_ch carrying
// the event code, the segment, offset and data of any request, and the
// program counter after the step.
// An item is decoded and, for simple operations, finished in the
// cycle after it is accepted, and its result is registered at the close
// of that cycle. Multiply and divide go through the shared bit-serial
// unit, which retires one bit per cycle; their result is registered once
// that unit reports done.
// The block takes one item at a time: in_ch.ready is high only while the
// core is idle and the output register is empty.
// When the receiver stalls, the result stays in the output register and no
// new item is taken until it is drained.
// Reset clears the registers, the program counter, the pending request and
// the halted flag, and empties the output register.
module universal_machine_execute_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    umec_in_if.sink    in_ch,
    umec_out_if.source out_ch
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [31:0] r_regs [umec_pkg::REG_COUNT];
    logic [31:0] r_pc;
    logic        r_pend;
    logic [umec_pkg::REG_IDX_W-1:0] r_pend_tgt;
    logic        r_halted;
    umec_pkg::t_in_item  r_item;
    umec_pkg::t_out_item r_out;
    logic        r_out_valid;
    logic [umec_pkg::REG_IDX_W-1:0] r_wait_tgt;

    umec_pkg::t_alu_ctrl w_alu_ctrl;
    umec_pkg::t_alu_stat w_alu_stat;
    logic [31:0] w_alu_res;

    logic [3:0]  w_op;
    logic [umec_pkg::REG_IDX_W-1:0] w_a, w_b, w_c, w_imm_a;
    logic [31:0] w_ra, w_rb, w_rc, w_npc;

    assign w_op = r_item.instruction[31:28];
    assign w_a = r_item.instruction[8:6];
    assign w_b = r_item.instruction[5:3];
    assign w_c = r_item.instruction[2:0];
    assign w_imm_a = r_item.instruction[27:25];
    assign w_ra = r_regs[w_a];
    assign w_rb = r_regs[w_b];
    assign w_rc = r_regs[w_c];
    assign w_npc = r_pc + 32'd1;

    assign in_ch.ready = (r_state == ST_IDLE) && !r_out_valid;
    assign out_ch.valid = r_out_valid;
    assign out_ch.payload = r_out;

    umec_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_alu_ctrl),
        .i_op_b   (w_rb),
        .i_op_c   (w_rc),
        .o_stat   (w_alu_stat),
        .o_result (w_alu_res)
    );

    // Decode: compute the result and any register write for the held item.
    logic        w_wr_en;
    logic [umec_pkg::REG_IDX_W-1:0] w_wr_idx;
    logic [31:0] w_wr_val;
    umec_pkg::t_out_item w_res;
    logic        w_set_pend, w_set_halt, w_clr_pend, w_start_alu, w_upd_pc;
    logic [umec_pkg::REG_IDX_W-1:0] w_pend_tgt;
    logic [31:0] w_new_pc;

    always_comb begin
        w_wr_en = 1'b0;
        w_wr_idx = w_a;
        w_wr_val = '0;
        w_res = '0;
        w_res.event_res = umec_pkg::EV_DONE;
        w_set_pend = 1'b0;
        w_clr_pend = 1'b0;
        w_set_halt = 1'b0;
        w_start_alu = 1'b0;
        w_upd_pc = 1'b0;
        w_pend_tgt = w_a;
        w_new_pc = w_npc;
        if (r_item.action) begin
            if (r_pend) begin
                w_wr_en = 1'b1;
                w_wr_idx = r_pend_tgt;
                w_wr_val = r_item.reply_value;
                w_clr_pend = 1'b1;
            end else begin
                w_res.event_res = umec_pkg::EV_NOTREADY;
            end
        end else if (r_halted) begin
            w_res.event_res = umec_pkg::EV_HALT;
        end else if (r_pend) begin
            w_res.event_res = umec_pkg::EV_NOTREADY;
        end else begin
            w_upd_pc = 1'b1;
            unique case (w_op)
                umec_pkg::OP_CMOV: begin
                    w_wr_en = (w_rc != 32'd0);
                    w_wr_val = w_rb;
                end
                umec_pkg::OP_LOAD: begin
                    w_res.event_res = umec_pkg::EV_READ;
                    w_res.segment_id = w_rb;
                    w_res.word_offset = w_rc;
                    w_set_pend = 1'b1;
                end
                umec_pkg::OP_STORE: begin
                    w_res.event_res = umec_pkg::EV_WRITE;
                    w_res.segment_id = w_ra;
                    w_res.word_offset = w_rb;
                    w_res.data_value = w_rc;
                end
                umec_pkg::OP_ADD: begin
                    w_wr_en = 1'b1;
                    w_wr_val = w_rb + w_rc;
                end
                umec_pkg::OP_MUL: w_start_alu = 1'b1;
                umec_pkg::OP_DIV: begin
                    if (w_rc == 32'd0) w_res.event_res = umec_pkg::EV_DIVZERO;
                    else w_start_alu = 1'b1;
                end
                umec_pkg::OP_NAND: begin
                    w_wr_en = 1'b1;
                    w_wr_val = ~(w_rb & w_rc);
                end
                umec_pkg::OP_HALT: begin
                    w_res.event_res = umec_pkg::EV_HALT;
                    w_set_halt = 1'b1;
                    w_new_pc = r_pc;
                end
                umec_pkg::OP_MAP: begin
                    w_res.event_res = umec_pkg::EV_MAP;
                    w_res.segment_id = w_rc;
                    w_set_pend = 1'b1;
                    w_pend_tgt = w_b;
                end
                umec_pkg::OP_UNMAP: begin
                    if (w_rc == 32'd0) begin
                        w_res.event_res = umec_pkg::EV_UNMAPZERO;
                    end else begin
                        w_res.event_res = umec_pkg::EV_UNMAP;
                        w_res.segment_id = w_rc;
                    end
                end
                umec_pkg::OP_OUT: begin
                    if (w_rc > 32'd255) begin
                        w_res.event_res = umec_pkg::EV_BADOUT;
                    end else begin
                        w_res.event_res = umec_pkg::EV_OUTPUT;
                        w_res.data_value = w_rc;
                    end
                end
                umec_pkg::OP_IN: begin
                    w_res.event_res = umec_pkg::EV_INPUT;
                    w_set_pend = 1'b1;
                    w_pend_tgt = w_c;
                end
                umec_pkg::OP_LDPRG: begin
                    w_res.event_res = umec_pkg::EV_LOADPROG;
                    w_res.segment_id = w_rb;
                    w_new_pc = w_rc;
                end
                umec_pkg::OP_LDIMM: begin
                    w_wr_en = 1'b1;
                    w_wr_idx = w_imm_a;
                    w_wr_val = {7'd0, r_item.instruction[24:0]};
                end
                default: w_res.event_res = umec_pkg::EV_BADOP;
            endcase
        end
        w_res.next_pc = w_upd_pc ? w_new_pc : r_pc;
    end

    assign w_alu_ctrl.start = (r_state == ST_EXEC) && w_start_alu;
    assign w_alu_ctrl.is_div = (w_op == umec_pkg::OP_DIV);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_ch.valid && in_ch.ready) n_state = ST_EXEC;
            ST_EXEC: n_state = w_start_alu ? ST_WAIT : ST_IDLE;
            ST_WAIT: if (w_alu_stat.done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc <= '0;
            r_pend <= 1'b0;
            r_pend_tgt <= '0;
            r_halted <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < umec_pkg::REG_COUNT; i++) r_regs[i] <= '0;
        end else begin
            r_state <= n_state;
            if (out_ch.valid && out_ch.ready) r_out_valid <= 1'b0;
            if (r_state == ST_EXEC) begin
                if (w_wr_en) r_regs[w_wr_idx] <= w_wr_val;
                if (w_set_pend) begin
                    r_pend <= 1'b1;
                    r_pend_tgt <= w_pend_tgt;
                end
                if (w_clr_pend) r_pend <= 1'b0;
                if (w_set_halt) r_halted <= 1'b1;
                if (w_upd_pc) r_pc <= w_new_pc;
                if (!w_start_alu) r_out_valid <= 1'b1;
            end
            if (r_state == ST_WAIT && w_alu_stat.done) begin
                r_regs[r_wait_tgt] <= w_alu_res;
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) r_item <= in_ch.payload;
        if (r_state == ST_EXEC) begin
            r_out <= w_res;
            r_wait_tgt <= w_a;
        end
    end
endmodule

>>> hw/rtl/umec_checker.sv
// Port-level checker for the universal machine execute core, bound to the top level.
// Depends on umec_pkg and the channel interfaces.
`timescale 1ns / 1ps
module umec_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic [3:0] i_event_res
);
    // One item at a time: no input is taken while a result waits.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input taken while a result waits");

    // An accepted item never shows its result in the very next cycle.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_out_valid)
        else $error("result too early");

    // Not ready after accepting an item.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready right after accept");

    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_event_res <= umec_pkg::EV_NOTREADY))
        else $error("event code out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid && $stable(i_event_res))
        else $error("stalled result changed");
endmodule

bind universal_machine_execute_core umec_checker u_umec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (in_ch.valid),
    .i_in_ready  (in_ch.ready),
    .i_out_valid (out_ch.valid),
    .i_out_ready (out_ch.ready),
    .i_event_res (out_ch.payload.event_res)
);

>>> test/tb_umec_scoreboard.sv
// Instruction-level predictor and result checker for the universal machine execute core.
// Depends on umec_pkg for event codes, opcodes and item types.
`timescale 1ns / 1ps
class umec_scoreboard;
    logic [31:0] regs [8];
    logic [31:0] pc;
    bit          awaiting_reply;
    logic [2:0]  reply_target;
    bit          is_halted;
    umec_pkg::t_out_item expected_q[$];
    int          mismatches;
    int          results_seen;
    int          stray_results;

    function new();
        foreach (regs[i]) regs[i] = '0;
        pc = '0;
        awaiting_reply = 0;
        reply_target = '0;
        is_halted = 0;
        mismatches = 0;
        results_seen = 0;
        stray_results = 0;
    endfunction

    // Executes one accepted item on the shadow machine and queues its result.
    function void note_accepted(umec_pkg::t_in_item it);
        umec_pkg::t_out_item r;
        logic [3:0]  op;
        logic [2:0]  ra, rb_i, rc_i;
        logic [31:0] vb, vc, npc;
        r = '0;
        r.event_res = umec_pkg::EV_DONE;
        if (it.action == umec_pkg::ACTION_REPLY) begin
            if (awaiting_reply) begin
                regs[reply_target] = it.reply_value;
                awaiting_reply = 0;
            end else begin
                r.event_res = umec_pkg::EV_NOTREADY;
            end
        end else if (is_halted) begin
            r.event_res = umec_pkg::EV_HALT;
        end else if (awaiting_reply) begin
            r.event_res = umec_pkg::EV_NOTREADY;
        end else begin
            op   = it.instruction[31:28];
            ra   = it.instruction[8:6];
            rb_i = it.instruction[5:3];
            rc_i = it.instruction[2:0];
            vb   = regs[rb_i];
            vc   = regs[rc_i];
            npc  = pc + 32'd1;
            case (op)
                umec_pkg::OP_CMOV: if (vc != 0) regs[ra] = vb;
                umec_pkg::OP_LOAD: begin
                    r.event_res = umec_pkg::EV_READ;
                    r.segment_id = vb;
                    r.word_offset = vc;
                    awaiting_reply = 1;
                    reply_target = ra;
                end
                umec_pkg::OP_STORE: begin
                    r.event_res = umec_pkg::EV_WRITE;
                    r.segment_id = regs[ra];
                    r.word_offset = vb;
                    r.data_value = vc;
                end
                umec_pkg::OP_ADD: regs[ra] = vb + vc;
                umec_pkg::OP_MUL: regs[ra] = vb * vc;
                umec_pkg::OP_DIV: begin
                    if (vc == 0) r.event_res = umec_pkg::EV_DIVZERO;
                    else regs[ra] = vb / vc;
                end
                umec_pkg::OP_NAND: regs[ra] = ~(vb & vc);
                umec_pkg::OP_HALT: begin
                    r.event_res = umec_pkg::EV_HALT;
                    is_halted = 1;
                    npc = pc;
                end
                umec_pkg::OP_MAP: begin
                    r.event_res = umec_pkg::EV_MAP;
                    r.segment_id = vc;
                    awaiting_reply = 1;
                    reply_target = rb_i;
                end
                umec_pkg::OP_UNMAP: begin
                    if (vc == 0) begin
                        r.event_res = umec_pkg::EV_UNMAPZERO;
                    end else begin
                        r.event_res = umec_pkg::EV_UNMAP;
                        r.segment_id = vc;
                    end
                end
                umec_pkg::OP_OUT: begin
                    if (vc > 32'd255) begin
                        r.event_res = umec_pkg::EV_BADOUT;
                    end else begin
                        r.event_res = umec_pkg::EV_OUTPUT;
                        r.data_value = vc;
                    end
                end
                umec_pkg::OP_IN: begin
                    r.event_res = umec_pkg::EV_INPUT;
                    awaiting_reply = 1;
                    reply_target = rc_i;
                end
                umec_pkg::OP_LDPRG: begin
                    r.event_res = umec_pkg::EV_LOADPROG;
                    r.segment_id = vb;
                    npc = vc;
                end
                umec_pkg::OP_LDIMM:
                    regs[it.instruction[27:25]] = {7'd0, it.instruction[24:0]};
                default: r.event_res = umec_pkg::EV_BADOP;
            endcase
            pc = npc;
        end
        r.next_pc = pc;
        expected_q.push_back(r);
    endfunction

    function void check_result(umec_pkg::t_out_item got);
        umec_pkg::t_out_item want;
        results_seen++;
        if (expected_q.size() == 0) begin
            stray_results++;
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %h", got);
            return;
        end
        want = expected_q.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: expected ev=%0d seg=%h off=%h data=%h pc=%h",
                         want.event_res, want.segment_id, want.word_offset,
                         want.data_value, want.next_pc);
                $display("          got      ev=%0d seg=%h off=%h data=%h pc=%h",
                         got.event_res, got.segment_id, got.word_offset,
                         got.data_value, got.next_pc);
            end
        end
    endfunction
endclass

>>> test/tb_universal_machine_execute_core.sv
// Top-level testbench for the universal machine execute core.
// Depends on umec_pkg, umec_if, the core RTL and the scoreboard class.
`timescale 1ns / 1ps
module tb_universal_machine_execute_core;
    logic i_clk;
    logic i_rst_n;

    umec_in_if  in_ch();
    umec_out_if out_ch();

    universal_machine_execute_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    umec_scoreboard machine_model;

    // Receiver control: a long hold-off request and a stall-pattern selector.
    bit hold_sink;
    int stall_mode;
    int items_sent;
    int long_stall_stalls;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // The scoreboard is updated at the accepting edge on both channels. The
    // edge samples the pre-edge values, since all drivers use nonblocking
    // assignments, so nothing here depends on event ordering.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            machine_model.note_accepted(in_ch.payload);
        if (i_rst_n && out_ch.valid && out_ch.ready)
            machine_model.check_result(out_ch.payload);
    end

    // The receiver stalls in one of several patterns: never, sometimes,
    // often, or in strict alternation. A long hold-off overrides all of them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_sink) begin
            out_ch.ready <= 1'b0;
            if (in_ch.valid && !in_ch.ready)
                long_stall_stalls++;
        end else begin
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= ($urandom_range(0, 2) == 0);
                default: out_ch.ready <= ~out_ch.ready;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 3);
    end

    // Offers one item and holds it until the block takes it.
    task automatic send_item(input umec_pkg::t_in_item it);
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        items_sent++;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic go_idle(input int cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic umec_pkg::t_in_item exec_word(input logic [31:0] w);
        umec_pkg::t_in_item it;
        it.action      = umec_pkg::ACTION_EXEC;
        it.instruction = w;
        it.reply_value = $urandom();
        return it;
    endfunction

    function automatic umec_pkg::t_in_item reply_word(input logic [31:0] v);
        umec_pkg::t_in_item it;
        it.action      = umec_pkg::ACTION_REPLY;
        it.instruction = $urandom();
        it.reply_value = v;
        return it;
    endfunction

    function automatic logic [31:0] encode(input logic [3:0] op, input logic [2:0] a,
                                           input logic [2:0] b,
                                           input logic [2:0] c);
        logic [31:0] w;
        w = $urandom();
        w[31:28] = op;
        w[8:6] = a;
        w[5:3] = b;
        w[2:0] = c;
        return w;
    endfunction

    function automatic logic [31:0] load_imm(input logic [2:0] a, input logic [24:0] v);
        logic [31:0] w;
        w = {umec_pkg::OP_LDIMM, a, v};
        return w;
    endfunction

    // Reply values are zero or small in two draws of five so that output, divide
    // and unmap hit their interesting branches, with full-width values mixed in.
    function automatic logic [31:0] random_reply();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return $urandom_range(0, 300);
            2: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Sends one random item; requests are normally followed by their reply.
    task automatic random_step(input bit allow_halt);
        logic [3:0] op;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 4) begin
            send_item(reply_word(random_reply()));
        end else if (sel < 7) begin
            send_item(exec_word($urandom()));
        end else begin
            op = 4'($urandom_range(0, 15));
            if (op == umec_pkg::OP_HALT && !allow_halt)
                op = umec_pkg::OP_ADD;
            if ((op == umec_pkg::OP_MUL || op == umec_pkg::OP_DIV) && $urandom_range(0, 1))
                op = umec_pkg::OP_NAND;
            if (op == umec_pkg::OP_LDIMM)
                send_item(exec_word(load_imm(3'($urandom()), 25'($urandom()))));
            else
                send_item(exec_word(encode(op, 3'($urandom()), 3'($urandom()),
                                           3'($urandom()))));
            if (op == umec_pkg::OP_LOAD || op == umec_pkg::OP_MAP ||
                op == umec_pkg::OP_IN) begin
                // Occasionally an instruction sneaks in before the reply.
                if ($urandom_range(0, 9) == 0)
                    send_item(exec_word($urandom()));
                send_item(reply_word(random_reply()));
            end
        end
        if ($urandom_range(0, 5) == 0)
            go_idle($urandom_range(1, 6));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (machine_model.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic reset_block();
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    initial begin
        int k;
        machine_model = new();
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        hold_sink     = 0;
        stall_mode    = 0;
        items_sent    = 0;
        long_stall_stalls = 0;
        reset_block();

        // Directed part: operand extremes, every opcode but halt and each corner case
        // (reply with nothing pending, execute while a reply is pending,
        // divide by zero, wide output, unmap of segment zero, bad opcodes).
        send_item(reply_word(32'h1234_5678));
        send_item(exec_word(load_imm(3'd1, 25'h1FF_FFFF)));
        send_item(exec_word(encode(umec_pkg::OP_NAND, 3'd2, 3'd0, 3'd0)));
        send_item(exec_word(encode(umec_pkg::OP_ADD, 3'd3, 3'd2, 3'd2)));
        send_item(exec_word(encode(umec_pkg::OP_MUL, 3'd4, 3'd2, 3'd1)));
        send_item(exec_word(encode(umec_pkg::OP_DIV, 3'd5, 3'd2, 3'd1)));
        send_item(exec_word(encode(umec_pkg::OP_DIV, 3'd5, 3'd2, 3'd0)));
        send_item(exec_word(encode(umec_pkg::OP_CMOV, 3'd6, 3'd2, 3'd0)));
        send_item(exec_word(encode(umec_pkg::OP_CMOV, 3'd6, 3'd2, 3'd1)));
        send_item(exec_word(encode(umec_pkg::OP_STORE, 3'd2, 3'd1, 3'd3)));
        send_item(exec_word(encode(umec_pkg::OP_OUT, 3'd0, 3'd0, 3'd2)));
        send_item(exec_word(load_imm(3'd7, 25'd255)));
        send_item(exec_word(encode(umec_pkg::OP_OUT, 3'd0, 3'd0, 3'd7)));
        send_item(exec_word(encode(umec_pkg::OP_UNMAP, 3'd0, 3'd0, 3'd0)));
        send_item(exec_word(encode(umec_pkg::OP_UNMAP, 3'd0, 3'd0, 3'd7)));
        send_item(exec_word(encode(umec_pkg::OP_LOAD, 3'd0, 3'd2, 3'd7)));
        send_item(exec_word(encode(umec_pkg::OP_ADD, 3'd0, 3'd0, 3'd0)));
        send_item(reply_word(32'hFFFF_FFFF));
        send_item(exec_word(encode(umec_pkg::OP_MAP, 3'd0, 3'd4, 3'd7)));
        send_item(reply_word(32'h0000_0001));
        send_item(exec_word(encode(umec_pkg::OP_IN, 3'd0, 3'd0, 3'd5)));
        send_item(reply_word(32'hFFFF_FFFF));
        send_item(exec_word({4'd14, 28'h0ABC_DEF}));
        send_item(exec_word({4'd15, 28'hFFF_FFFF}));
        send_item(exec_word(encode(umec_pkg::OP_LDPRG, 3'd0, 3'd2, 3'd2)));

        // One sender pause until every expected result has come back.
        wait_drained();

        // Long receiver hold-off while the sender keeps offering items, so
        // the output register fills and the input side backs up.
        hold_sink <= 1;
        fork
            begin
                repeat (200) @(posedge i_clk);
                hold_sink <= 0;
            end
            for (k = 0; k < 20; k++)
                random_step(0);
        join

        // Main random part with bursts and gaps; near the end the machine is
        // allowed to halt so that the halted state is exercised too.
        while (items_sent < 560) begin
            for (k = $urandom_range(1, 30); k > 0; k--)
                random_step(items_sent > 500);
            go_idle($urandom_range(0, 12));
        end
        send_item(exec_word(encode(umec_pkg::OP_HALT, 3'd0, 3'd0, 3'd0)));
        send_item(exec_word($urandom()));
        send_item(reply_word($urandom()));
        wait_drained();

        $display("tb: %0d items sent, %0d results checked", items_sent,
                 machine_model.results_seen);
        $display("tb: input held back %0d cycles during the long receiver stall",
                 long_stall_stalls);
        if (machine_model.mismatches == 0 && machine_model.expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches, %0d left over", machine_model.mismatches,
                     machine_model.expected_q.size());
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/umec_pkg.sv
hw/rtl/umec_if.sv
hw/rtl/umec_alu.sv
hw/rtl/universal_machine_execute_core.sv
hw/rtl/umec_checker.sv
test/tb_umec_scoreboard.sv
test/tb_universal_machine_execute_core.sv
